@@ design/cms_pkg.sv @@
package cms_pkg;

    localparam int WORD_W  = 32;
    localparam int DIV_W   = 2 * WORD_W;
    localparam int SHIFT_W = 6;
    localparam int CNT_W   = 7;

    localparam logic [SHIFT_W-1:0] MAX_SHIFT = SHIFT_W'(WORD_W);
    localparam logic [CNT_W-1:0]   DIV_STEPS = CNT_W'(DIV_W);

    typedef struct packed {
        logic [WORD_W-1:0] source_freq;
        logic [WORD_W-1:0] target_freq;
        logic [WORD_W-1:0] range_seconds;
    } cms_in_t;

    typedef struct packed {
        logic [WORD_W-1:0]  mult_factor;
        logic [SHIFT_W-1:0] shift_amount;
        logic               div_zero_error;
    } cms_out_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [WORD_W-1:0] divisor;
    } cms_div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } cms_div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LIMIT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_CHECK,
        ST_DONE
    } cms_state_t;

endpackage

@@ design/cms_div.sv @@
module cms_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cms_pkg::cms_div_req_t req,
    output cms_pkg::cms_div_rsp_t rsp
);

    logic [cms_pkg::DIV_W-1:0]  dq_reg, dq_next;
    logic [cms_pkg::WORD_W-1:0] rem_reg, rem_next;
    logic [cms_pkg::WORD_W-1:0] dvs_reg, dvs_next;
    logic [cms_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [cms_pkg::WORD_W:0]   partial;
    logic [cms_pkg::WORD_W:0]   diff;
    logic                       take;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    assign partial = {rem_reg, dq_reg[cms_pkg::DIV_W-1]};
    assign diff    = partial - {1'b0, dvs_reg};
    assign take    = (partial >= {1'b0, dvs_reg});

    always_comb begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            dq_next   = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = cms_pkg::DIV_STEPS;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dq_next  = {dq_reg[cms_pkg::DIV_W-2:0], take};
            rem_next = take ? diff[cms_pkg::WORD_W-1:0] : partial[cms_pkg::WORD_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == cms_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule

@@ design/clock_mult_shift_calc.sv @@
// Multiplier and shift calculator for scaled clock conversion: a count at
// source_freq becomes a count at target_freq as (count * mult_factor) >>
// shift_amount, exact enough over range_seconds without overflow. One word in
// gives one word out. The block takes one word at a time and drops s_ready
// while it works. Steps: take the word, form the range product, then shorten
// the shift limit by one per significant bit of the product's upper half (up
// to 32), then per trial shift start the shared radix-2 divider, wait out its
// 64 steps, capture the quotient and compare it with the limit, trying shifts
// 32 down to 1, and load the result. A zero source frequency skips the
// divider and finishes with div_zero_error set. A finished result waits in
// the output register, and the next word may be taken meanwhile.
module clock_mult_shift_calc (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cms_pkg::cms_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cms_pkg::cms_out_t m_data
);

    cms_pkg::cms_state_t state_reg, state_next;

    logic [cms_pkg::WORD_W-1:0]  src_reg, src_next;
    logic [cms_pkg::WORD_W-1:0]  dst_reg, dst_next;
    logic [cms_pkg::WORD_W-1:0]  rng_reg, rng_next;
    logic [cms_pkg::WORD_W-1:0]  hi_reg, hi_next;
    logic [cms_pkg::SHIFT_W-1:0] limit_reg, limit_next;
    logic [cms_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic [cms_pkg::DIV_W-1:0]   q_reg, q_next;
    logic                        err_reg, err_next;
    cms_pkg::cms_out_t           out_reg, out_next;
    logic                        m_valid_reg, m_valid_next;

    cms_pkg::cms_div_req_t       div_req;
    cms_pkg::cms_div_rsp_t       div_rsp;
    logic                        div_start;

    logic [cms_pkg::DIV_W-1:0]   prod;
    logic [cms_pkg::DIV_W-1:0]   high_mask;
    logic                        fits;

    assign prod = {{cms_pkg::WORD_W{1'b0}}, rng_reg} * {{cms_pkg::WORD_W{1'b0}}, src_reg};

    // quotient fits when no bit at or above the limit is set
    assign high_mask = ~((cms_pkg::DIV_W'(1) << limit_reg) - cms_pkg::DIV_W'(1));
    assign fits      = ((q_reg & high_mask) == '0);

    // rounded quotient: (target << shift + source / 2) / source
    assign div_req.start    = div_start;
    assign div_req.dividend = ({{cms_pkg::WORD_W{1'b0}}, dst_reg} << shift_reg)
                            + {{(cms_pkg::WORD_W+1){1'b0}}, src_reg[cms_pkg::WORD_W-1:1]};
    assign div_req.divisor  = src_reg;

    cms_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cms_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        src_reg   <= src_next;
        dst_reg   <= dst_next;
        rng_reg   <= rng_next;
        hi_reg    <= hi_next;
        limit_reg <= limit_next;
        shift_reg <= shift_next;
        q_reg     <= q_next;
        err_reg   <= err_next;
        out_reg   <= out_next;
    end

    always_comb begin
        state_next    = state_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        rng_next      = rng_reg;
        hi_next       = hi_reg;
        limit_next    = limit_reg;
        shift_next    = shift_reg;
        q_next        = q_reg;
        err_next      = err_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg;
        div_start     = 1'b0;
        s_ready       = 1'b0;

        // drop the held result once it is taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            cms_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    src_next   = s_data.source_freq;
                    dst_next   = s_data.target_freq;
                    rng_next   = s_data.range_seconds;
                    state_next = cms_pkg::ST_MUL;
                end
            end
            cms_pkg::ST_MUL: begin
                hi_next    = prod[cms_pkg::DIV_W-1:cms_pkg::WORD_W];
                limit_next = cms_pkg::MAX_SHIFT;
                shift_next = cms_pkg::MAX_SHIFT;
                if (src_reg == '0) begin
                    // zero source frequency: no division, flag the error
                    q_next     = '0;
                    shift_next = '0;
                    err_next   = 1'b1;
                    state_next = cms_pkg::ST_DONE;
                end else begin
                    err_next   = 1'b0;
                    state_next = cms_pkg::ST_LIMIT;
                end
            end
            cms_pkg::ST_LIMIT: begin
                // shorten the limit by one per significant bit of the high half
                if (hi_reg != '0) begin
                    hi_next    = hi_reg >> 1;
                    limit_next = limit_reg - 1'b1;
                end else begin
                    state_next = cms_pkg::ST_DIV_START;
                end
            end
            cms_pkg::ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = cms_pkg::ST_DIV_WAIT;
            end
            cms_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    q_next     = div_rsp.quotient;
                    state_next = cms_pkg::ST_CHECK;
                end
            end
            cms_pkg::ST_CHECK: begin
                if (fits) begin
                    state_next = cms_pkg::ST_DONE;
                end else if (shift_reg == cms_pkg::SHIFT_W'(1)) begin
                    // no shift fits: keep the quotient of shift one
                    shift_next = '0;
                    state_next = cms_pkg::ST_DONE;
                end else begin
                    shift_next = shift_reg - 1'b1;
                    state_next = cms_pkg::ST_DIV_START;
                end
            end
            cms_pkg::ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_next.mult_factor    = q_reg[cms_pkg::WORD_W-1:0];
                    out_next.shift_amount   = shift_reg;
                    out_next.div_zero_error = err_reg;
                    m_valid_next            = 1'b1;
                    state_next              = cms_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cms_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_err_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.div_zero_error) |->
            (m_data.mult_factor == '0 && m_data.shift_amount == '0))
        else $error("error word carries nonzero fields");

    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.shift_amount <= cms_pkg::MAX_SHIFT))
        else $error("shift amount above maximum");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> (src_reg != '0 && shift_reg != '0))
        else $error("divider started with zero divisor or zero shift");
`endif

endmodule
